// ===== rtl/dmvic_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex index cache package
// Shared payload types, widths and codes of the direct-mapped vertex cache.
// ----------------------------------------------------------------------------
package dmvic_pkg;

   localparam int VIDX_W      = 32;
   localparam int FLAGS_W     = 16;
   localparam int ELT_W       = 16;
   localparam int CNT_W       = $clog2(VIDX_W + 1);
   localparam int Q_DEPTH     = 2;
   localparam int EPOCH_W     = 8;
   localparam int FLUSH_MARGIN = 6;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;

   typedef struct packed {
      logic [VIDX_W-1:0]  vertex_index;
      logic [FLAGS_W-1:0] vertex_flags;
      logic               prim_end;
      logic               draw_end;
   } req_type;

   typedef struct packed {
      logic [ELT_W-1:0]  draw_element;
      logic              fetch_valid;
      logic [VIDX_W-1:0] fetch_index;
      logic              batch_flush;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } back_state_type;

endpackage

// ===== rtl/dmvic_front.sv =====
// ----------------------------------------------------------------------------
// Vertex cache front end
// Accepts request words and maps each vertex index onto its cache slot.
// ----------------------------------------------------------------------------
module dmvic_front #(
   parameter int  CACHE_SLOTS = 256,
   localparam int IDX_W       = $clog2(CACHE_SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dmvic_pkg::req_type req_data,
   input  logic               hold_off,
   input  logic               queue_full,
   output logic               push,
   output dmvic_pkg::req_type push_item,
   output logic [IDX_W-1:0]   push_slot
);
   import dmvic_pkg::*;

   localparam bit SLOTS_POW2 = (CACHE_SLOTS & (CACHE_SLOTS - 1)) == 0;

   logic    busy_ff, busy_in;
   req_type item_ff, item_in;
   logic    accept;
   logic    slot_done;
   logic [IDX_W-1:0] slot_val;

   assign push      = busy_ff && slot_done && !queue_full;
   assign req_stall = (busy_ff && !push) || hold_off;
   assign accept    = req_valid && !req_stall;
   assign push_item = item_ff;
   assign push_slot = slot_val;

   always_comb begin
      busy_in = accept || (busy_ff && !push);
      item_in = accept ? req_data : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   generate
      if (SLOTS_POW2) begin : g_pow2
         // low index bits select the slot
         assign slot_done = 1'b1;
         assign slot_val  = item_ff.vertex_index[IDX_W-1:0];
      end else begin : g_recip
         // reciprocal multiply for the quotient; the estimate falls short by
         // at most one, so one compare and subtract finishes the remainder
         localparam int                SHIFT      = VIDX_W - 1 + IDX_W;
         localparam int                PROD_W     = 2 * VIDX_W;
         localparam logic [63:0]       RECIP_WIDE = (64'd1 << SHIFT) / 64'(CACHE_SLOTS);
         localparam logic [VIDX_W-1:0] RECIP      = RECIP_WIDE[VIDX_W-1:0];
         localparam logic [IDX_W:0]    SLOTS_MOD  = (IDX_W + 1)'(CACHE_SLOTS);

         logic              ready_ff, ready_in;
         logic [IDX_W:0]    quot_ff, quot_in;
         logic [PROD_W-1:0] product;
         logic [IDX_W:0]    rem_raw;
         logic [IDX_W:0]    rem_fix;

         assign slot_done = ready_ff;
         assign slot_val  = rem_fix[IDX_W-1:0];

         always_comb begin
            product  = PROD_W'(item_ff.vertex_index) * PROD_W'(RECIP);
            // only the low quotient bits matter for the remainder
            quot_in  = product[SHIFT +: IDX_W + 1];
            rem_raw  = item_ff.vertex_index[IDX_W:0] - quot_ff * SLOTS_MOD;
            rem_fix  = (rem_raw >= SLOTS_MOD) ? rem_raw - SLOTS_MOD : rem_raw;
            ready_in = busy_ff && !accept;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ready_ff <= 1'b0;
            end else begin
               ready_ff <= ready_in;
            end
         end

         always_ff @(posedge clock) begin
            quot_ff <= quot_in;
         end
      end
   endgenerate

endmodule

// ===== rtl/dmvic_queue.sv =====
// ----------------------------------------------------------------------------
// Vertex cache decoupling queue
// Short first-in first-out buffer between the front end and the lookup.
// ----------------------------------------------------------------------------
module dmvic_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   import dmvic_pkg::*;

   localparam int PTR_W  = $clog2(Q_DEPTH);
   localparam int FILL_W = $clog2(Q_DEPTH + 1);

   logic [WIDTH-1:0]  entries_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = fill_ff == FILL_W'(Q_DEPTH);
   assign valid    = fill_ff != '0;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/dmvic_back.sv =====
// ----------------------------------------------------------------------------
// Vertex cache lookup engine
// Tag read, compare and update, fetch numbering, batch flush and result word.
// ----------------------------------------------------------------------------
module dmvic_back #(
   parameter int  CACHE_SLOTS = 256,
   parameter int  FETCH_LIMIT = 256,
   parameter int  DRAW_LIMIT  = 16384,
   localparam int IDX_W       = $clog2(CACHE_SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               q_valid,
   input  dmvic_pkg::req_type q_item,
   input  logic [IDX_W-1:0]   q_slot,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dmvic_pkg::rsp_type rsp_data
);
   import dmvic_pkg::*;

   localparam int SN_W = $clog2(FETCH_LIMIT);
   localparam int FC_W = $clog2(FETCH_LIMIT + 1);
   localparam int DC_W = $clog2(DRAW_LIMIT + 1);

   localparam logic [FC_W-1:0]  FETCH_FULL = FC_W'(FETCH_LIMIT);
   localparam logic [FC_W-1:0]  FETCH_NEAR = FC_W'(FETCH_LIMIT - FLUSH_MARGIN);
   localparam logic [DC_W-1:0]  DRAW_FULL  = DC_W'(DRAW_LIMIT);
   localparam logic [DC_W-1:0]  DRAW_NEAR  = DC_W'(DRAW_LIMIT - FLUSH_MARGIN);
   localparam logic [IDX_W-1:0] CLR_LAST   = IDX_W'(CACHE_SLOTS - 1);

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [VIDX_W-1:0]  tag;
      logic [SN_W-1:0]    slot_num;
   } entry_type;

   entry_type tag_ram [CACHE_SLOTS];

   back_state_type   state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [FC_W-1:0]  fetch_cnt_ff, fetch_cnt_in;
   logic [DC_W-1:0]  draw_cnt_ff, draw_cnt_in;
   logic             pass_flags_ff, pass_flags_in;
   req_type          work_ff, work_in;
   logic [IDX_W-1:0] work_slot_ff, work_slot_in;
   entry_type        rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             rd_en, produce, clr_step;
   logic             out_free, hit, miss, flush, epoch_wrap, clr_last;
   logic [FC_W-1:0]  fc_new;
   logic [DC_W-1:0]  dc_new;
   logic [SN_W-1:0]  sn_sel;
   logic [ELT_W-1:0] elt;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit        = (rd_data_ff.epoch == epoch_ff) &&
                       (rd_data_ff.tag == work_ff.vertex_index);
   assign miss       = !hit;
   assign fc_new     = fetch_cnt_ff + FC_W'(miss);
   assign dc_new     = draw_cnt_ff + DC_W'(1);
   assign flush      = (work_ff.prim_end && (dc_new >= DRAW_NEAR || fc_new >= FETCH_NEAR))
                       || work_ff.draw_end || fc_new >= FETCH_FULL || dc_new >= DRAW_FULL;
   assign sn_sel     = miss ? fetch_cnt_ff[SN_W-1:0] : rd_data_ff.slot_num;
   assign elt        = ELT_W'(sn_sel) | (pass_flags_ff ? work_ff.vertex_flags : '0);
   assign epoch_wrap = epoch_ff == '1;
   assign clr_last   = clr_ff == CLR_LAST;

   assign clearing   = state_ff == ST_CLEAR;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (out_free) state_in = (flush && epoch_wrap) ? ST_CLEAR : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      produce  = 1'b0;
      clr_step = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clr_step = 1'b1;
         ST_IDLE: begin
            q_pop = q_valid;
            rd_en = q_valid;
         end
         ST_LOOKUP: produce = out_free;
         default: clr_step = 1'b0;
      endcase
   end

   always_comb begin
      mem_we  = clr_step || (produce && miss);
      wr_addr = clr_step ? clr_ff : work_slot_ff;
      wr_data = clr_step ? entry_type'{epoch: EPOCH_EMPTY, tag: '1, slot_num: '0}
                         : entry_type'{epoch: epoch_ff, tag: work_ff.vertex_index,
                                       slot_num: fetch_cnt_ff[SN_W-1:0]};

      clr_in        = clr_step ? (clr_last ? '0 : clr_ff + IDX_W'(1)) : clr_ff;
      epoch_in      = epoch_ff;
      fetch_cnt_in  = fetch_cnt_ff;
      draw_cnt_in   = draw_cnt_ff;
      if (produce) begin
         if (flush) begin
            epoch_in     = epoch_wrap ? EPOCH_FIRST : epoch_ff + EPOCH_W'(1);
            fetch_cnt_in = '0;
            draw_cnt_in  = '0;
         end else begin
            fetch_cnt_in = fc_new;
            draw_cnt_in  = dc_new;
         end
      end

      pass_flags_in = csr_write_enable ? csr_write_data : pass_flags_ff;
      work_in       = q_pop ? q_item : work_ff;
      work_slot_in  = q_pop ? q_slot : work_slot_ff;

      rsp_valid_in  = produce || (rsp_valid_ff && rsp_stall);
      rsp_data_in   = rsp_data_ff;
      if (produce) begin
         rsp_data_in.draw_element = elt;
         rsp_data_in.fetch_valid  = miss;
         rsp_data_in.fetch_index  = miss ? work_ff.vertex_index : '0;
         rsp_data_in.batch_flush  = flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         epoch_ff      <= EPOCH_FIRST;
         clr_ff        <= '0;
         fetch_cnt_ff  <= '0;
         draw_cnt_ff   <= '0;
         pass_flags_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         clr_ff        <= clr_in;
         fetch_cnt_ff  <= fetch_cnt_in;
         draw_cnt_ff   <= draw_cnt_in;
         pass_flags_ff <= pass_flags_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      work_slot_ff <= work_slot_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= tag_ram[q_slot];
      end
   end

   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (fetch_cnt_ff < FETCH_FULL) && (draw_cnt_ff < DRAW_FULL))
      else $error("batch counter reached its limit");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      produce && flush |=> (fetch_cnt_ff == '0) && (draw_cnt_ff == '0))
      else $error("flush did not clear the batch counters");

   a_miss_numbers: assert property (@(posedge clock) disable iff (reset)
      produce && miss && !flush |=> fetch_cnt_ff == $past(fetch_cnt_ff) + FC_W'(1))
      else $error("miss did not take the next fetch number");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !q_pop && !produce)
      else $error("lookup ran during the clearing pass");

   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      produce && flush && epoch_wrap |=> (state_ff == ST_CLEAR) && (clr_ff == '0))
      else $error("epoch wrap did not start a clearing pass");

endmodule

// ===== rtl/direct_mapped_vertex_index_cache.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped vertex index cache
// Looks up vertex indices in a direct-mapped tag store, numbers fetches on a
// miss, emits draw elements and ends batches at draw end and near the fetch and draw limits.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_stall  vertex_index, vertex_flags,
//                                              prim_end, draw_end
//   rsp_     out        rsp_valid / rsp_stall  draw_element, fetch_valid,
//                                              fetch_index, batch_flush
//   csr_     in         csr_write_enable       pass_flags (csr_write_data)
//
// Lookup: the engine reads the tag memory, then compares, updates and writes
//   the result, and takes no new word from the queue until that is done.
//   With CACHE_SLOTS not a power of two the front end registers a reciprocal
//   multiply quotient for the slot, which still keeps up with the lookup.
// Reset: a clearing pass writes every tag entry empty; req_stall stays high
//   meanwhile. Flushes bump an 8-bit epoch mark, and every 255th flush
//   repeats the clearing pass.
// Stalls: a two-word queue separates the front end from the lookup, and the
//   result register holds a word while rsp_stall is high.
// ----------------------------------------------------------------------------
module direct_mapped_vertex_index_cache #(
   parameter int CACHE_SLOTS = 256,
   parameter int FETCH_LIMIT = 256,
   parameter int DRAW_LIMIT  = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dmvic_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dmvic_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);
   import dmvic_pkg::*;

   localparam int IDX_W = $clog2(CACHE_SLOTS);
   localparam int REQ_W = $bits(req_type);
   localparam int Q_W   = IDX_W + REQ_W;

   // front end to queue
   logic             push;
   req_type          push_item;
   logic [IDX_W-1:0] push_slot;

   // queue to lookup engine
   logic             q_full, q_valid, q_pop;
   logic [Q_W-1:0]   q_data;
   req_type          q_item;
   logic [IDX_W-1:0] q_slot;

   // hold off new words while the tag memory is being cleared
   logic             clearing;

   assign q_item = req_type'(q_data[REQ_W-1:0]);
   assign q_slot = q_data[REQ_W +: IDX_W];

   // accept a word and find its slot
   dmvic_front #(
      .CACHE_SLOTS(CACHE_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .hold_off   (clearing),
      .queue_full (q_full),
      .push       (push),
      .push_item  (push_item),
      .push_slot  (push_slot)
   );

   // decouple the front end from the lookup
   dmvic_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_slot, push_item}),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   // tag lookup, fetch numbering, batch flush and result register
   dmvic_back #(
      .CACHE_SLOTS(CACHE_SLOTS),
      .FETCH_LIMIT(FETCH_LIMIT),
      .DRAW_LIMIT (DRAW_LIMIT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_slot           (q_slot),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule
